// ===== hw/rtl/spimte_pkg.sv =====
package spimte_pkg;

  // Item command codes
  typedef enum logic [1:0] {
    CmdLoad  = 2'd0,
    CmdStart = 2'd1,
    CmdEvent = 2'd2,
    CmdNop   = 2'd3
  } cmd_e;

  // Message flag bit positions
  localparam int unsigned FlBusHold      = 0;
  localparam int unsigned FlXfer         = 1;
  localparam int unsigned FlXferComplete = 2;
  localparam int unsigned FlBusRelease   = 3;
  localparam int unsigned FlComplete     = 4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  channel;
    logic [7:0]  index;
    logic [7:0]  data_byte;
    logic [8:0]  tx_length;
    logic [15:0] rx_skip;
    logic [15:0] rx_take;
    logic        select_cs;
    logic        hold_bus;
    logic        rx_ready;
    logic        tx_empty;
    logic        bus_error;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        tx_valid;
    logic [7:0]  tx_data;
    logic        rx_valid;
    logic [15:0] rx_index;
    logic [7:0]  rx_data;
    logic [15:0] transferred;
    logic [4:0]  msg_flags;
    logic        cs_active;
    logic [2:0]  bus_owner;
    logic        error_seen;
  } out_item_t;

endpackage

// ===== hw/rtl/spimte_if.sv =====
interface spimte_in_if;
  import spimte_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface spimte_out_if;
  import spimte_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/spimte_tx_store.sv =====
module spimte_tx_store #(
  parameter int unsigned TX_DEPTH = 256
) (
  input  logic                                            clk_i,
  input  logic                                            we_i,
  input  logic [((TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1)-1:0] waddr_i,
  input  logic [7:0]                                      wdata_i,
  input  logic [((TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1)-1:0] raddr_i,
  output logic [7:0]                                      rdata_o
);

  logic [7:0] mem_q [TX_DEPTH];
  logic [7:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, forward a write to the same entry
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/spimte_ctrl.sv =====
module spimte_ctrl #(
  parameter int unsigned TX_DEPTH     = 256,
  parameter int unsigned NUM_CHANNELS = 8,
  parameter int unsigned FRAME_BITS   = 8
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            fire_i,
  input  spimte_pkg::in_item_t                            item_i,
  input  logic [7:0]                                      rd_data_i,
  output logic                                            we_o,
  output logic [((TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1)-1:0] waddr_o,
  output logic [7:0]                                      wdata_o,
  output logic [((TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1)-1:0] raddr_o,
  output spimte_pkg::out_item_t                           res_o
);
  import spimte_pkg::*;

  localparam int unsigned AddrW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam logic [7:0] FrameMask =
      (FRAME_BITS >= 8) ? 8'hFF : 8'((1 << FRAME_BITS) - 1);

  logic [15:0] rx_count_q, rx_count_d;
  logic [15:0] tx_count_q, tx_count_d;
  logic [15:0] msg_len_q, msg_len_d;
  logic [8:0]  cur_txl_q, cur_txl_d;
  logic [15:0] cur_skip_q, cur_skip_d;
  logic [15:0] cur_take_q, cur_take_d;
  logic        cur_hold_q, cur_hold_d;
  logic [2:0]  owner_q, owner_d;
  logic        held_q, held_d;
  logic [4:0]  flags_q, flags_d;
  logic        cs_q, cs_d;
  logic        rx_en_q, rx_en_d;
  logic        tx_en_q, tx_en_d;

  logic [16:0] len_sum;
  logic [16:0] len_full;
  logic        start_ok;
  logic        finish;
  logic [15:0] rx_rel;
  logic [8:0]  pos_d;
  cmd_e        cmd;

  assign cmd = cmd_e'(item_i.cmd);

  // Message length and start admission
  always_comb begin
    len_sum  = {1'b0, item_i.rx_skip} + {1'b0, item_i.rx_take};
    len_full = ({8'b0, item_i.tx_length} > len_sum) ? {8'b0, item_i.tx_length} : len_sum;
    start_ok = !rx_en_q && (32'(item_i.channel) < NUM_CHANNELS) &&
               (!held_q || (owner_q == item_i.channel)) &&
               (32'(item_i.tx_length) <= TX_DEPTH) && !len_full[16];
  end

  assign rx_rel = rx_count_q - cur_skip_q;

  // Store write for load items
  assign we_o    = fire_i && (cmd == CmdLoad) && (32'(item_i.index) < TX_DEPTH);
  assign waddr_o = AddrW'(item_i.index);
  assign wdata_o = item_i.data_byte;

  // Next state and result
  always_comb begin
    rx_count_d = rx_count_q;
    tx_count_d = tx_count_q;
    msg_len_d  = msg_len_q;
    cur_txl_d  = cur_txl_q;
    cur_skip_d = cur_skip_q;
    cur_take_d = cur_take_q;
    cur_hold_d = cur_hold_q;
    owner_d    = owner_q;
    held_d     = held_q;
    flags_d    = flags_q;
    cs_d       = cs_q;
    rx_en_d    = rx_en_q;
    tx_en_d    = tx_en_q;
    finish     = 1'b0;
    res_o      = '0;

    if (fire_i) begin
      case (cmd)
        CmdStart: begin
          if (start_ok) begin
            res_o.accepted = 1'b1;
            owner_d    = item_i.channel;
            held_d     = 1'b1;
            cur_txl_d  = item_i.tx_length;
            cur_skip_d = item_i.rx_skip;
            cur_take_d = item_i.rx_take;
            cur_hold_d = item_i.hold_bus;
            msg_len_d  = len_full[15:0];
            rx_count_d = '0;
            tx_count_d = '0;
            flags_d    = '0;
            if (item_i.select_cs) begin
              cs_d = 1'b1;
              flags_d[FlBusHold] = 1'b1;
            end
            if (len_full != '0) begin
              flags_d[FlXfer] = 1'b1;
              rx_en_d = 1'b1;
              tx_en_d = 1'b1;
            end else begin
              finish = 1'b1;
            end
          end
        end
        CmdEvent: begin
          if (item_i.bus_error) begin
            res_o.error_seen = 1'b1;
          end else if (rx_en_q) begin
            // Receive side: deliver inside the take window
            if (item_i.rx_ready) begin
              if ((rx_count_q >= cur_skip_q) && (rx_rel < cur_take_q)) begin
                res_o.rx_valid = 1'b1;
                res_o.rx_index = rx_rel;
                res_o.rx_data  = item_i.data_byte & FrameMask;
              end
              rx_count_d = rx_count_q + 16'd1;
            end
            // Transmit side: prefetched store byte, or zero without data
            if (item_i.tx_empty && tx_en_q && (tx_count_q < msg_len_q)) begin
              res_o.tx_valid = 1'b1;
              res_o.tx_data  = (cur_txl_q == '0) ? 8'd0 : (rd_data_i & FrameMask);
              tx_count_d = tx_count_q + 16'd1;
              if (tx_count_d >= msg_len_q) begin
                tx_en_d = 1'b0;
              end
            end
            if (rx_count_d >= msg_len_q) begin
              finish = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase

      // Complete the message, release the bus unless held
      if (finish) begin
        rx_en_d = 1'b0;
        tx_en_d = 1'b0;
        flags_d[FlXferComplete] = 1'b1;
        if (!cur_hold_d) begin
          cs_d   = 1'b0;
          held_d = 1'b0;
          flags_d[FlBusRelease] = 1'b1;
        end
        flags_d[FlComplete] = 1'b1;
      end
    end

    res_o.transferred = (rx_count_d < tx_count_d) ? rx_count_d : tx_count_d;
    res_o.msg_flags   = flags_d;
    res_o.cs_active   = cs_d;
    res_o.bus_owner   = held_d ? owner_d : 3'd0;
  end

  // Read ahead: address the store at the frame position of the next state
  always_comb begin
    if (cur_txl_d == '0) begin
      pos_d = '0;
    end else if (tx_count_d < {7'b0, cur_txl_d}) begin
      pos_d = tx_count_d[8:0];
    end else begin
      pos_d = cur_txl_d - 9'd1;
    end
  end

  assign raddr_o = AddrW'(pos_d);

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_count_q <= '0;
      tx_count_q <= '0;
      msg_len_q  <= '0;
      cur_txl_q  <= '0;
      cur_skip_q <= '0;
      cur_take_q <= '0;
      cur_hold_q <= 1'b0;
      owner_q    <= '0;
      held_q     <= 1'b0;
      flags_q    <= '0;
      cs_q       <= 1'b0;
      rx_en_q    <= 1'b0;
      tx_en_q    <= 1'b0;
    end else begin
      rx_count_q <= rx_count_d;
      tx_count_q <= tx_count_d;
      msg_len_q  <= msg_len_d;
      cur_txl_q  <= cur_txl_d;
      cur_skip_q <= cur_skip_d;
      cur_take_q <= cur_take_d;
      cur_hold_q <= cur_hold_d;
      owner_q    <= owner_d;
      held_q     <= held_d;
      flags_q    <= flags_d;
      cs_q       <= cs_d;
      rx_en_q    <= rx_en_d;
      tx_en_q    <= tx_en_d;
    end
  end

endmodule

// ===== hw/rtl/spimte_out_buf.sv =====
module spimte_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  spimte_pkg::out_item_t in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output spimte_pkg::out_item_t out_data_o
);
  import spimte_pkg::*;

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t out_data_q, out_data_d;
  out_item_t skid_data_q, skid_data_d;
  logic      in_fire;
  logic      out_fire;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && out_ready_i;

  // Steer the new result into the output or the skid stage
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_data_d  = in_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = in_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/spi_message_transfer_engine.sv =====
// SPI master message engine, full duplex, one result per input item.
// Input channel in_i carries load, start, bus event and no-op items; every
// accepted item produces exactly one result on out_o, in order.
// Load writes a transmit byte into the transmit store; start claims the bus
// for a channel and opens a message; a bus event steps the receive and
// transmit cursors and reports the delivered and sent frames.
// Throughput: one item per cycle while in_i.ready is high. Each result is
// registered in the output buffer before it appears on out_o. The store is read
// ahead at the frame position of the next state, with a write to the same entry
// forwarded, so the transmit frame is ready when the next bus event arrives.
// Reset clears all message state and the bus ownership; the store keeps no
// reset value and needs no clearing pass, so items are taken right away.
// When the receiver stalls, results wait in an output register plus one skid
// stage; in_i.ready drops only when both are full.
module spi_message_transfer_engine #(
  parameter int unsigned TX_DEPTH     = 256,
  parameter int unsigned NUM_CHANNELS = 8,
  parameter int unsigned FRAME_BITS   = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  spimte_in_if.sink     in_i,
  spimte_out_if.source  out_o
);
  import spimte_pkg::*;

  localparam int unsigned AddrW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  logic             in_ready;
  logic             in_fire;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic [7:0]       mem_rdata;
  out_item_t        result;

  assign in_i.ready = in_ready;
  assign in_fire    = in_i.valid && in_ready;

  spimte_tx_store #(
    .TX_DEPTH (TX_DEPTH)
  ) u_tx_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  spimte_ctrl #(
    .TX_DEPTH     (TX_DEPTH),
    .NUM_CHANNELS (NUM_CHANNELS),
    .FRAME_BITS   (FRAME_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (in_fire),
    .item_i    (in_i.data),
    .rd_data_i (mem_rdata),
    .we_o      (mem_we),
    .waddr_o   (mem_waddr),
    .wdata_o   (mem_wdata),
    .raddr_o   (mem_raddr),
    .res_o     (result)
  );

  spimte_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .in_data_i   (result),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule
